[src/wlp_pkg.sv]
// ----------------------------------------------------------------------------
// wlp_pkg
// Shared types and constants of the windowed latency percentile core.
// ----------------------------------------------------------------------------
package wlp_pkg;

   localparam int BUCKETS          = 23;
   localparam int MINUTE_SLOTS     = 59;
   localparam int HOUR_SLOTS       = 23;
   localparam int COUNT_WIDTH      = 32;
   localparam int TICKS_PER_MINUTE = 60;
   localparam int PCT_SCALE        = 100;
   localparam int PCT_ROUND        = 50;

   localparam int LAT_W        = 32;
   localparam int WIN_W        = 6;
   localparam int REQ_USER_W   = 3;
   localparam int REQ_DATA_W   = 40;
   localparam int STATUS_W     = 2;
   localparam int BUCKET_OUT_W = 5;
   localparam int TOTAL_OUT_W  = 32;
   localparam int RSP_DATA_W   = 40;
   localparam int LO_EXP_W     = 5;
   localparam int HI_EXP_W     = 6;
   localparam int RANK_W       = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 7;

   typedef enum logic [REQ_USER_W-1:0] {
      REQ_SAMPLE = 3'd0,
      REQ_TICK   = 3'd1,
      REQ_MINUTE = 3'd2,
      REQ_HOUR   = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_WINDOW = 2'd1,
      STATUS_DISABLED   = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOW_EXP  = 2'd0,
      CSR_HIGH_EXP = 2'd1,
      CSR_RANK     = 2'd2,
      CSR_ENABLE   = 2'd3
   } csr_index_type;

endpackage

[src/wlp_ram.sv]
// ----------------------------------------------------------------------------
// wlp_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module wlp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/wlp_div.sv]
// ----------------------------------------------------------------------------
// wlp_div
// Restoring divider, one quotient bit per cycle, used for the bucket index.
// ----------------------------------------------------------------------------
module wlp_div #(
   parameter int DW  = 40,
   parameter int QOW = 33,
   parameter int SW  = 6
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [SW-1:0]  steps,
   input  logic [DW-1:0]  dividend,
   input  logic [DW-1:0]  divisor,
   output logic           done,
   output logic [QOW-1:0] quotient
);

   logic [DW-1:0]  rem_ff;
   logic [DW-1:0]  dsh_ff;
   logic [QOW-1:0] q_ff;
   logic [SW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic           ge;

   assign ge = (rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= dividend;
            dsh_ff  <= divisor;
            q_ff    <= '0;
            cnt_ff  <= steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            q_ff   <= {q_ff[QOW-2:0], ge};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == SW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

[src/windowed_latency_percentile_core.sv]
// ----------------------------------------------------------------------------
// windowed_latency_percentile_core
// Log-bucket latency histogram with minute and hour rings and percentile query.
// ----------------------------------------------------------------------------
// A sample passes through the clamp, leading-one search, fraction and scaling,
// divider load, one divider step per index bit, divider finish and counter
// update; with an inverted or empty exponent range it goes straight to the
// counter update in bucket 0. A tick or a query walks the rings bucket by
// bucket, reading each stored slot and summing it into a saturating
// accumulator, and a query then sums the buckets cumulatively up to the
// percentile target before its response. Clear and unknown requests are
// handled in the idle state. The ring memories need no clearing pass.
module windowed_latency_percentile_core #(
   parameter int BUCKETS      = wlp_pkg::BUCKETS,
   parameter int MINUTE_SLOTS = wlp_pkg::MINUTE_SLOTS,
   parameter int HOUR_SLOTS   = wlp_pkg::HOUR_SLOTS,
   parameter int COUNT_WIDTH  = wlp_pkg::COUNT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // latency [31:0], window [37:32]
   input  logic [wlp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type [2:0]
   input  logic [wlp_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // percentile_bucket [4:0], window_total [36:5]
   output logic [wlp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status [1:0]
   output logic [wlp_pkg::STATUS_W-1:0]      rsp_tuser,
   input  logic                              csr_we,
   input  logic [wlp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wlp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import wlp_pkg::*;

   localparam int CW  = COUNT_WIDTH;
   localparam int BW  = $clog2(BUCKETS);
   localparam int MP  = MINUTE_SLOTS + 1;
   localparam int HP  = HOUR_SLOTS + 1;
   localparam int MSW = $clog2(MP);
   localparam int HSW = $clog2(HP);
   localparam int MD  = MP * BUCKETS;
   localparam int HD  = HP * BUCKETS;
   localparam int MAW = $clog2(MD);
   localparam int HAW = $clog2(HD);
   localparam int DW  = CW + 8;
   localparam int QOW = CW + 1;
   localparam int SW  = $clog2(CW + 2);
   localparam int NUMW = 13 + BW;
   localparam int TW  = (CW > TOTAL_OUT_W) ? CW : TOTAL_OUT_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LZ, ST_FRAC, ST_DIV_BKT, ST_INC,
      ST_BK_INIT, ST_RD_M, ST_ACC_M, ST_RD_H, ST_ACC_H, ST_BK_DONE,
      ST_CUM, ST_OUT
   } state_type;

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW] ? {CW{1'b1}} : s[CW-1:0];
   endfunction

   state_type            state_ff;
   logic [LO_EXP_W-1:0]  lo_ff;
   logic [HI_EXP_W-1:0]  hi_ff;
   logic [RANK_W-1:0]    rank_ff;
   logic                 en_ff;
   logic [CW-1:0]        sh_ff [BUCKETS];
   logic [CW-1:0]        accbuf_ff [BUCKETS];
   logic [CW-1:0]        acc_ff;
   logic [CW-1:0]        total_ff;
   logic [CW-1:0]        cum_ff;
   logic [BW-1:0]        bkt_ff;
   logic [BW-1:0]        idx_ff;
   logic [LAT_W-1:0]     v_ff;
   logic [4:0]           e_ff;
   logic [MSW-1:0]       mhead_ff, mtail_ff, m_slot_ff, m_left_ff, n_m_ff;
   logic [HSW-1:0]       hhead_ff, htail_ff, h_slot_ff, h_left_ff, n_h_ff;
   logic [5:0]           sim_ff;
   logic                 is_tick_ff;
   logic                 push_hour_ff;
   logic                 rsp_tvalid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff, res_status_ff;
   logic [BUCKET_OUT_W-1:0] rsp_bucket_ff, res_bucket_ff;
   logic [TOTAL_OUT_W-1:0]  rsp_total_ff, res_total_ff;
   logic                 div_start_ff;
   logic [SW-1:0]        div_steps_ff;
   logic [DW-1:0]        div_a_ff, div_d_ff;

   logic                 div_done;
   logic [QOW-1:0]       div_q;
   req_kind_type         req_kind;
   logic [LAT_W-1:0]     req_lat;
   logic [WIN_W-1:0]     req_win;
   logic [LAT_W-1:0]     lo_pow, hi_pow, v_in;
   logic [4:0]           e_in;
   logic [7:0]           f_in;
   logic [12:0]          diff;
   logic [NUMW-1:0]      num;
   logic [13:0]          den;
   logic [BW-1:0]        sh_idx;
   logic [CW-1:0]        sh_rd;
   logic [CW-1:0]        acc_m_in, acc_h_in, cum_in;
   logic [MSW-1:0]       cnt_m, m_slot_dec, mtail_inc, mhead_inc;
   logic [HSW-1:0]       cnt_h, h_slot_dec, htail_inc, hhead_inc;
   logic [MAW-1:0]       m_raddr, m_waddr;
   logic [HAW-1:0]       h_raddr, h_waddr;
   logic [CW-1:0]        m_rdata, h_rdata;
   logic                 m_we, h_we;
   logic [CW+7:0]        prod;
   logic [CW+7:0]        cum_scaled;
   logic [TW-1:0]        total_wide;

   assign req_kind = req_kind_type'(req_tuser);
   assign req_lat  = req_tdata[LAT_W-1:0];
   assign req_win  = req_tdata[LAT_W+WIN_W-1:LAT_W];
   assign req_tready = (state_ff == ST_IDLE);

   // clamp
   always_comb begin
      lo_pow = LAT_W'(1) << lo_ff;
      hi_pow = LAT_W'(1) << hi_ff[4:0];
      v_in   = (req_lat < lo_pow) ? lo_pow : req_lat;
      if (hi_ff < HI_EXP_W'(LAT_W) && v_in > hi_pow) begin
         v_in = hi_pow;
      end
   end

   always_comb begin
      e_in = '0;
      for (int i = 0; i < LAT_W; i++) begin
         if (v_ff[i]) begin
            e_in = 5'(i);
         end
      end
   end

   always_comb begin
      logic [LAT_W-1:0] sv;
      sv = (e_ff >= 5'd8) ? (v_ff >> (e_ff - 5'd8)) : (v_ff << (5'd8 - e_ff));
      f_in = sv[7:0];
      diff = {e_ff, f_in} - {lo_ff, 8'b0};
      num  = NUMW'(diff) * NUMW'(BUCKETS - 1);
      den  = {hi_ff - {1'b0, lo_ff}, 8'b0};
   end

   assign sh_idx = (state_ff == ST_INC) ? idx_ff : bkt_ff;
   assign sh_rd  = sh_ff[sh_idx];

   assign acc_m_in = sat_add(acc_ff, m_rdata);
   assign acc_h_in = sat_add(acc_ff, h_rdata);
   assign cum_in   = sat_add(cum_ff, accbuf_ff[bkt_ff]);

   assign cnt_m = mtail_ff - mhead_ff + ((mtail_ff < mhead_ff) ? MSW'(MP) : '0);
   assign cnt_h = htail_ff - hhead_ff + ((htail_ff < hhead_ff) ? HSW'(HP) : '0);
   assign m_slot_dec = (m_slot_ff == '0) ? MSW'(MP - 1) : m_slot_ff - 1'b1;
   assign h_slot_dec = (h_slot_ff == '0) ? HSW'(HP - 1) : h_slot_ff - 1'b1;
   assign mtail_inc  = (mtail_ff == MSW'(MP - 1)) ? '0 : mtail_ff + 1'b1;
   assign mhead_inc  = (mhead_ff == MSW'(MP - 1)) ? '0 : mhead_ff + 1'b1;
   assign htail_inc  = (htail_ff == HSW'(HP - 1)) ? '0 : htail_ff + 1'b1;
   assign hhead_inc  = (hhead_ff == HSW'(HP - 1)) ? '0 : hhead_ff + 1'b1;

   assign m_raddr = MAW'(32'(m_slot_dec) * 32'(BUCKETS) + 32'(bkt_ff));
   assign h_raddr = HAW'(32'(h_slot_dec) * 32'(BUCKETS) + 32'(bkt_ff));
   assign m_waddr = MAW'(32'(mtail_ff) * 32'(BUCKETS) + 32'(bkt_ff));
   assign h_waddr = HAW'(32'(htail_ff) * 32'(BUCKETS) + 32'(bkt_ff));
   assign m_we = (state_ff == ST_BK_DONE) && is_tick_ff;
   assign h_we = (state_ff == ST_BK_DONE) && is_tick_ff && push_hour_ff;

   // cum reaches the rounded target when 100*cum + 49 >= total*rank
   assign prod       = (CW+8)'(total_ff) * (CW+8)'(rank_ff);
   assign cum_scaled = (CW+8)'(cum_in) * (CW+8)'(PCT_SCALE) +
                       (CW+8)'(PCT_SCALE - PCT_ROUND - 1);
   assign total_wide = TW'(total_ff);

   wlp_ram #(.WIDTH(CW), .DEPTH(MD)) u_minute_ring (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (sh_rd),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   wlp_ram #(.WIDTH(CW), .DEPTH(HD)) u_hour_ring (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (acc_ff),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   wlp_div #(.DW(DW), .QOW(QOW), .SW(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .steps    (div_steps_ff),
      .dividend (div_a_ff),
      .divisor  (div_d_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lo_ff         <= '0;
         hi_ff         <= HI_EXP_W'(20);
         rank_ff       <= RANK_W'(99);
         en_ff         <= 1'b0;
         mhead_ff      <= '0;
         mtail_ff      <= '0;
         hhead_ff      <= '0;
         htail_ff      <= '0;
         sim_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         for (int i = 0; i < BUCKETS; i++) begin
            sh_ff[i] <= '0;
         end
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  case (req_kind)
                     REQ_SAMPLE: begin
                        if (en_ff) begin
                           v_ff <= v_in;
                           if (hi_ff <= {1'b0, lo_ff}) begin
                              idx_ff   <= '0;
                              state_ff <= ST_INC;
                           end else begin
                              state_ff <= ST_LZ;
                           end
                        end
                     end
                     REQ_TICK: begin
                        if (en_ff) begin
                           is_tick_ff   <= 1'b1;
                           push_hour_ff <= (sim_ff >= 6'(TICKS_PER_MINUTE - 1));
                           n_m_ff       <= (sim_ff >= 6'(TICKS_PER_MINUTE - 1)) ?
                                           cnt_m : '0;
                           n_h_ff       <= '0;
                           bkt_ff       <= '0;
                           state_ff     <= ST_BK_INIT;
                        end
                     end
                     REQ_MINUTE, REQ_HOUR: begin
                        res_bucket_ff <= '0;
                        res_total_ff  <= '0;
                        is_tick_ff    <= 1'b0;
                        bkt_ff        <= '0;
                        total_ff      <= '0;
                        if (!en_ff) begin
                           res_status_ff <= STATUS_DISABLED;
                           state_ff      <= ST_OUT;
                        end else if (req_win == '0 ||
                                     (req_kind == REQ_HOUR &&
                                      {1'b0, req_win} > 7'(HOUR_SLOTS)) ||
                                     (req_kind == REQ_MINUTE &&
                                      {1'b0, req_win} > 7'(MINUTE_SLOTS))) begin
                           res_status_ff <= STATUS_BAD_WINDOW;
                           state_ff      <= ST_OUT;
                        end else begin
                           res_status_ff <= STATUS_OK;
                           if (req_kind == REQ_HOUR) begin
                              n_m_ff <= (7'(sim_ff) < 7'(cnt_m)) ? MSW'(sim_ff) : cnt_m;
                              n_h_ff <= (7'(req_win) < 7'(cnt_h)) ? HSW'(req_win) : cnt_h;
                           end else begin
                              n_m_ff <= (7'(req_win) < 7'(cnt_m)) ? MSW'(req_win) : cnt_m;
                              n_h_ff <= '0;
                           end
                           state_ff <= ST_BK_INIT;
                        end
                     end
                     REQ_CLEAR: begin
                        mhead_ff <= '0;
                        mtail_ff <= '0;
                        hhead_ff <= '0;
                        htail_ff <= '0;
                        sim_ff   <= '0;
                        for (int i = 0; i < BUCKETS; i++) begin
                           sh_ff[i] <= '0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_LZ: begin
               e_ff     <= e_in;
               state_ff <= ST_FRAC;
            end
            ST_FRAC: begin
               div_a_ff     <= DW'({num, 1'b0}) + DW'(den);
               div_d_ff     <= DW'(den) << BW;
               div_steps_ff <= SW'(BW);
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIV_BKT;
            end
            ST_DIV_BKT: begin
               if (div_done) begin
                  idx_ff   <= (div_q > QOW'(BUCKETS - 1)) ? BW'(BUCKETS - 1) : div_q[BW-1:0];
                  state_ff <= ST_INC;
               end
            end
            ST_INC: begin
               sh_ff[idx_ff] <= sat_add(sh_rd, CW'(1));
               state_ff      <= ST_IDLE;
            end
            ST_BK_INIT: begin
               acc_ff    <= sh_rd;
               m_left_ff <= n_m_ff;
               m_slot_ff <= mtail_ff;
               h_left_ff <= n_h_ff;
               h_slot_ff <= htail_ff;
               state_ff  <= ST_RD_M;
            end
            ST_RD_M: begin
               if (m_left_ff != '0) begin
                  m_slot_ff <= m_slot_dec;
                  m_left_ff <= m_left_ff - 1'b1;
                  state_ff  <= ST_ACC_M;
               end else begin
                  state_ff <= ST_RD_H;
               end
            end
            ST_ACC_M: begin
               acc_ff   <= acc_m_in;
               state_ff <= ST_RD_M;
            end
            ST_RD_H: begin
               if (h_left_ff != '0) begin
                  h_slot_ff <= h_slot_dec;
                  h_left_ff <= h_left_ff - 1'b1;
                  state_ff  <= ST_ACC_H;
               end else begin
                  state_ff <= ST_BK_DONE;
               end
            end
            ST_ACC_H: begin
               acc_ff   <= acc_h_in;
               state_ff <= ST_RD_H;
            end
            ST_BK_DONE: begin
               if (!is_tick_ff) begin
                  accbuf_ff[bkt_ff] <= acc_ff;
                  total_ff          <= sat_add(total_ff, acc_ff);
               end
               if (bkt_ff == BW'(BUCKETS - 1)) begin
                  if (is_tick_ff) begin
                     if (push_hour_ff) begin
                        htail_ff <= htail_inc;
                        if (htail_inc == hhead_ff) begin
                           hhead_ff <= hhead_inc;
                        end
                        sim_ff <= 6'd1;
                     end else begin
                        sim_ff <= sim_ff + 6'd1;
                     end
                     mtail_ff <= mtail_inc;
                     if (mtail_inc == mhead_ff) begin
                        mhead_ff <= mhead_inc;
                     end
                     for (int i = 0; i < BUCKETS; i++) begin
                        sh_ff[i] <= '0;
                     end
                     state_ff <= ST_IDLE;
                  end else begin
                     bkt_ff   <= '0;
                     cum_ff   <= '0;
                     state_ff <= ST_CUM;
                  end
               end else begin
                  bkt_ff   <= bkt_ff + 1'b1;
                  state_ff <= ST_BK_INIT;
               end
            end
            ST_CUM: begin
               cum_ff <= cum_in;
               if (cum_scaled >= prod || bkt_ff == BW'(BUCKETS - 1)) begin
                  res_bucket_ff <= BUCKET_OUT_W'(bkt_ff);
                  res_total_ff  <= (total_wide > TW'({TOTAL_OUT_W{1'b1}})) ?
                                   {TOTAL_OUT_W{1'b1}} : TOTAL_OUT_W'(total_wide);
                  state_ff      <= ST_OUT;
               end else begin
                  bkt_ff <= bkt_ff + 1'b1;
               end
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_bucket_ff <= res_bucket_ff;
                  rsp_total_ff  <= res_total_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_LOW_EXP:  lo_ff   <= csr_wdata[LO_EXP_W-1:0];
               CSR_HIGH_EXP: hi_ff   <= csr_wdata[HI_EXP_W-1:0];
               CSR_RANK:     rank_ff <= csr_wdata[RANK_W-1:0];
               CSR_ENABLE: begin
                  en_ff <= csr_wdata[0];
                  if (en_ff && !csr_wdata[0]) begin
                     mhead_ff <= '0;
                     mtail_ff <= '0;
                     hhead_ff <= '0;
                     htail_ff <= '0;
                     sim_ff   <= '0;
                     for (int i = 0; i < BUCKETS; i++) begin
                        sh_ff[i] <= '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - TOTAL_OUT_W - BUCKET_OUT_W){1'b0}},
                        rsp_total_ff, rsp_bucket_ff};

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !en_ff &&
      (req_kind == REQ_MINUTE || req_kind == REQ_HOUR) |=> state_ff == ST_OUT)
      else $error("disabled query did not go straight to the response");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_BKT)
      else $error("divider finished outside a divide step");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INC |-> {1'b0, idx_ff} < (BW+1)'(BUCKETS))
      else $error("bucket index beyond histogram");

   assert property (@(posedge clock) disable iff (reset)
      {1'b0, mtail_ff} < (MSW+1)'(MP) && {1'b0, mhead_ff} < (MSW+1)'(MP) &&
      {1'b0, htail_ff} < (HSW+1)'(HP) && {1'b0, hhead_ff} < (HSW+1)'(HP))
      else $error("ring pointer out of range");

endmodule
